@@ rtl/core/lick_side_detector_unit_macros.svh @@
// assertion helpers for the lick side detector, clocked on clk, held off in reset
`ifndef LICK_SIDE_DETECTOR_UNIT_MACROS_SVH
`define LICK_SIDE_DETECTOR_UNIT_MACROS_SVH

// same-cycle implication
`define LSD_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lsd assertion failed");

// next-cycle implication
`define LSD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lsd assertion failed");

`endif

@@ rtl/core/lsd_pkg.sv @@
// ----------------------------------------------------------------------------
// lsd_pkg
// Shared types and constants of the lick side detector.
// ----------------------------------------------------------------------------
package lsd_pkg;

    localparam int BAL_W       = 11;
    localparam int MS_W        = 32;
    localparam int PERIOD_W    = 16;
    localparam int DEB_W       = 10;
    localparam int CNT_W       = 32;
    localparam int DATA_W      = 32;
    localparam int CFG_ADDR_W  = 5;
    localparam int SCALE_SHIFT = 10;
    localparam int BLINK_BIT   = 9;

    localparam logic [BAL_W-1:0] BAL_ZERO_SUM = 11'd512;

    localparam logic [BAL_W-1:0]    THRESH_HIGH_RST  = 11'd1023;
    localparam logic [BAL_W-1:0]    THRESH_LOW_RST   = 11'd0;
    localparam logic [DEB_W-1:0]    DEBOUNCE_RST     = 10'd10;
    localparam logic [PERIOD_W-1:0] REPORT_PERIOD_RST = 16'd500;

    typedef logic [1:0] side_t;
    localparam side_t SIDE_NONE  = 2'd0;
    localparam side_t SIDE_LEFT  = 2'd1;
    localparam side_t SIDE_RIGHT = 2'd2;

    typedef logic [1:0] level_t;
    localparam level_t LEVEL_IN    = 2'd0;
    localparam level_t LEVEL_ABOVE = 2'd1;
    localparam level_t LEVEL_BELOW = 2'd2;

    typedef enum logic [2:0] {
        REG_THRESH_HIGH   = 3'd0,
        REG_THRESH_LOW    = 3'd1,
        REG_DEBOUNCE_MS   = 3'd2,
        REG_REPORT_PERIOD = 3'd3,
        REG_CHART_ENABLE  = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [BAL_W-1:0]    thresh_high;
        logic [BAL_W-1:0]    thresh_low;
        logic [DEB_W-1:0]    debounce_ms;
        logic [PERIOD_W-1:0] report_period_ms;
        logic                chart_enable;
    } cfg_t;

endpackage

@@ rtl/core/lsd_in_if.sv @@
// ----------------------------------------------------------------------------
// lsd_in_if
// Tick channel: sensor samples and link state of one timer tick.
// ----------------------------------------------------------------------------
interface lsd_in_if #(
    parameter int SAMPLE_BITS = 10
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] adc_left;
    logic [SAMPLE_BITS-1:0] adc_right;
    logic                   link_busy;

    modport source (output valid, output adc_left, output adc_right, output link_busy,
                    input ready);
    modport sink   (input valid, input adc_left, input adc_right, input link_busy,
                    output ready);
endinterface

@@ rtl/core/lsd_out_if.sv @@
// ----------------------------------------------------------------------------
// lsd_out_if
// Result channel: balance, lick events, level report and counters per tick.
// ----------------------------------------------------------------------------
interface lsd_out_if;
    import lsd_pkg::*;

    logic             valid;
    logic             ready;
    logic [BAL_W-1:0] balance;
    side_t            lick_event;
    logic             report_valid;
    logic             chart_valid;
    level_t           level_flag;
    logic             detect_pin;
    logic             blink;
    logic [CNT_W-1:0] left_total;
    logic [CNT_W-1:0] right_total;
    side_t            stable_side;

    modport source (output valid, output balance, output lick_event, output report_valid,
                    output chart_valid, output level_flag, output detect_pin, output blink,
                    output left_total, output right_total, output stable_side,
                    input ready);
    modport sink   (input valid, input balance, input lick_event, input report_valid,
                    input chart_valid, input level_flag, input detect_pin, input blink,
                    input left_total, input right_total, input stable_side,
                    output ready);
endinterface

@@ rtl/core/lick_side_detector_unit.sv @@
// the back part takes one tick item at a time, paced by the 32-bit report-phase remainder unit
// retiring 2 bits a cycle; the balance divider finishes inside that window
// an accepted tick goes through the queue and both dividers into the result register
// a 2-entry queue and the result register let ticks and results stall independently
// async active-low reset clears counters, detector and queue, and loads register defaults
// ----------------------------------------------------------------------------
// lick_side_detector_unit
// Top level: APB register file, front part, queue and back part.
// ----------------------------------------------------------------------------
`include "lick_side_detector_unit_macros.svh"

module lick_side_detector_unit #(
    parameter int SAMPLE_BITS = 10,
    parameter int TICK_MS     = 5,
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lsd_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [lsd_pkg::DATA_W-1:0]      pwdata,
    output logic [lsd_pkg::DATA_W-1:0]      prdata,
    output logic                            pready,
    lsd_in_if.sink                          tick,
    lsd_out_if.source                       result
);
    import lsd_pkg::*;

    localparam int ENTRY_W = 2 * SAMPLE_BITS + 3;

    cfg_t cfg_reg;

    logic               fifo_push, fifo_pop, fifo_full, fifo_empty;
    logic [ENTRY_W-1:0] push_entry, pop_entry;
    logic               cfg_write;
    logic [2:0]         reg_sel;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_sel   = paddr[CFG_ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.thresh_high      <= THRESH_HIGH_RST;
            cfg_reg.thresh_low       <= THRESH_LOW_RST;
            cfg_reg.debounce_ms      <= DEBOUNCE_RST;
            cfg_reg.report_period_ms <= REPORT_PERIOD_RST;
            cfg_reg.chart_enable     <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                REG_THRESH_HIGH:   cfg_reg.thresh_high      <= pwdata[BAL_W-1:0];
                REG_THRESH_LOW:    cfg_reg.thresh_low       <= pwdata[BAL_W-1:0];
                REG_DEBOUNCE_MS:   cfg_reg.debounce_ms      <= pwdata[DEB_W-1:0];
                REG_REPORT_PERIOD: cfg_reg.report_period_ms <= pwdata[PERIOD_W-1:0];
                REG_CHART_ENABLE:  cfg_reg.chart_enable     <= pwdata[0];
                default:           cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_THRESH_HIGH:   prdata = DATA_W'(cfg_reg.thresh_high);
            REG_THRESH_LOW:    prdata = DATA_W'(cfg_reg.thresh_low);
            REG_DEBOUNCE_MS:   prdata = DATA_W'(cfg_reg.debounce_ms);
            REG_REPORT_PERIOD: prdata = DATA_W'(cfg_reg.report_period_ms);
            REG_CHART_ENABLE:  prdata = DATA_W'(cfg_reg.chart_enable);
            default:           prdata = '0;
        endcase
    end

    lsd_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .tick  (tick),
        .full  (fifo_full),
        .push  (fifo_push),
        .entry (push_entry)
    );

    lsd_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (fifo_push),
        .wr_data (push_entry),
        .pop     (fifo_pop),
        .rd_data (pop_entry),
        .full    (fifo_full),
        .empty   (fifo_empty)
    );

    lsd_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .TICK_MS     (TICK_MS)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .empty  (fifo_empty),
        .entry  (pop_entry),
        .pop    (fifo_pop),
        .result (result)
    );

    `LSD_ASSERT_IMPLIES(a_pop_nonempty, fifo_pop, !fifo_empty)
    `LSD_ASSERT_IMPLIES(a_push_room, fifo_push, !fifo_full)
    `LSD_ASSERT_NEXT(a_pop_spaced, fifo_pop, !fifo_pop)
    `LSD_ASSERT_IMPLIES(a_event_pin, result.valid && result.lick_event != SIDE_NONE, result.detect_pin && result.stable_side == result.lick_event)
    `LSD_ASSERT_IMPLIES(a_level_needs_report, result.valid && (result.chart_valid || result.level_flag != LEVEL_IN), result.report_valid)

endmodule

@@ rtl/core/lsd_divider.sv @@
// ----------------------------------------------------------------------------
// lsd_divider
// Restoring divider, STEP_BITS quotient bits per cycle.
// ----------------------------------------------------------------------------
module lsd_divider #(
    parameter int DVD_W     = 20,
    parameter int DVS_W     = 11,
    parameter int STEP_BITS = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             busy,
    output logic [DVD_W-1:0] quotient,
    output logic [DVS_W-1:0] remainder
);
    localparam int STEPS = (DVD_W + STEP_BITS - 1) / STEP_BITS;
    localparam int PAD_W = STEPS * STEP_BITS;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [PAD_W-1:0] work_reg, work_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;

    always_comb
    begin : step_logic
        logic [DVS_W:0]   trial;
        logic [DVS_W-1:0] r;
        logic [PAD_W-1:0] w;
        logic             q;
        r = rem_reg;
        w = work_reg;
        for (int s = 0; s < STEP_BITS; s++)
        begin
            trial = {r, w[PAD_W-1]};
            q     = (trial >= {1'b0, dvs_reg});
            if (q)
            begin
                trial = trial - {1'b0, dvs_reg};
            end
            r = trial[DVS_W-1:0];
            w = {w[PAD_W-2:0], q};
        end
        rem_next  = r;
        work_next = w;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            run_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg <= CNT_W'(STEPS);
            run_reg <= 1'b1;
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                run_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= PAD_W'(dividend);
            rem_reg  <= '0;
            dvs_reg  <= divisor;
        end
        else if (run_reg)
        begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
        end
    end

    assign busy      = run_reg;
    assign quotient  = work_reg[DVD_W-1:0];
    assign remainder = rem_reg;

endmodule

@@ rtl/core/lsd_front.sv @@
// ----------------------------------------------------------------------------
// lsd_front
// Takes tick items, forms the sample sum and zero-sum flag, queues the entry.
// ----------------------------------------------------------------------------
module lsd_front #(
    parameter  int SAMPLE_BITS = 10,
    localparam int ENTRY_W     = 2 * SAMPLE_BITS + 3
) (
    lsd_in_if.sink              tick,
    input  logic                full,
    output logic                push,
    output logic [ENTRY_W-1:0]  entry
);
    logic [SAMPLE_BITS:0] sum;
    logic                 zero_sum;

    assign sum      = {1'b0, tick.adc_left} + {1'b0, tick.adc_right};
    assign zero_sum = (sum == '0);

    assign tick.ready = !full;
    assign push       = tick.valid && !full;

    // entry layout: busy, zero flag, sum, left sample
    assign entry = {tick.link_busy, zero_sum, sum, tick.adc_left};

endmodule

@@ rtl/core/lsd_fifo.sv @@
// ----------------------------------------------------------------------------
// lsd_fifo
// Short queue between the front and back parts.
// ----------------------------------------------------------------------------
module lsd_fifo #(
    parameter  int WIDTH = 23,
    parameter  int DEPTH = 2,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ rtl/core/lsd_back.sv @@
// ----------------------------------------------------------------------------
// lsd_back
// Advances the ms counter, divides out the balance and report phase,
// runs the debounce detector and holds the result register.
// ----------------------------------------------------------------------------
module lsd_back #(
    parameter  int SAMPLE_BITS = 10,
    parameter  int TICK_MS     = 5,
    localparam int ENTRY_W     = 2 * SAMPLE_BITS + 3
) (
    input  logic               clk,
    input  logic               rst_n,
    input  lsd_pkg::cfg_t      cfg,
    input  logic               empty,
    input  logic [ENTRY_W-1:0] entry,
    output logic               pop,
    lsd_out_if.source          result
);
    import lsd_pkg::*;

    localparam int SUM_W = SAMPLE_BITS + 1;
    localparam int DVD_W = SAMPLE_BITS + SCALE_SHIFT;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_CALC = 2'b10
    } state_t;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'b001,
        PH_DEBOUNCE = 3'b010,
        PH_SENT     = 3'b100
    } phase_t;

    state_t st_reg, st_next;
    phase_t phase_reg, phase_next;

    logic [MS_W-1:0]  ms_reg, ms_tick;
    logic [MS_W-1:0]  start_reg, start_next;
    logic [CNT_W-1:0] left_reg, left_next;
    logic [CNT_W-1:0] right_reg, right_next;
    side_t            side_reg, side_next;
    logic             pin_reg, pin_next;
    logic             zero_reg;
    logic             busy_reg;
    logic             out_valid_reg;

    logic [BAL_W-1:0] bal_reg;
    side_t            event_reg;
    logic             rep_reg;
    logic             chart_reg;
    level_t           level_reg;
    logic             blink_reg;

    logic [DVD_W-1:0]    sel_q;
    logic [PERIOD_W-1:0] mod_rem;
    logic                sel_busy, mod_busy;
    logic                slot_free, finish;

    logic [BAL_W-1:0] sel;
    logic             in_band, above, below, expired, rep;
    side_t            event_c;
    level_t           level_c;
    logic [MS_W-1:0]  deadline;

    assign ms_tick   = ms_reg + MS_W'(TICK_MS);
    assign slot_free = !out_valid_reg || result.ready;
    assign finish    = (st_reg == ST_CALC) && !sel_busy && !mod_busy && slot_free;
    assign pop       = ((st_reg == ST_IDLE) || finish) && !empty;

    lsd_divider #(
        .DVD_W     (DVD_W),
        .DVS_W     (SUM_W),
        .STEP_BITS (2)
    ) u_sel_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (pop),
        .dividend  ({entry[SAMPLE_BITS-1:0], {SCALE_SHIFT{1'b0}}}),
        .divisor   (entry[2*SAMPLE_BITS:SAMPLE_BITS]),
        .busy      (sel_busy),
        .quotient  (sel_q),
        .remainder ()
    );

    // ms counter phase within the report period
    lsd_divider #(
        .DVD_W     (MS_W),
        .DVS_W     (PERIOD_W),
        .STEP_BITS (2)
    ) u_mod_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (pop),
        .dividend  (ms_tick),
        .divisor   (cfg.report_period_ms),
        .busy      (mod_busy),
        .quotient  (),
        .remainder (mod_rem)
    );

    always_comb
    begin
        // for a nonzero sum the quotient never exceeds 1024 so the low bits carry it whole
        sel      = zero_reg ? BAL_ZERO_SUM : sel_q[BAL_W-1:0];
        in_band  = (sel <= cfg.thresh_high) && (sel >= cfg.thresh_low);
        above    = (sel > cfg.thresh_high);
        below    = (sel < cfg.thresh_low);
        deadline = start_reg + MS_W'(cfg.debounce_ms);
        expired  = (ms_reg > deadline);

        phase_next = phase_reg;
        start_next = start_reg;
        left_next  = left_reg;
        right_next = right_reg;
        side_next  = side_reg;
        pin_next   = pin_reg;
        event_c    = SIDE_NONE;

        if (in_band)
        begin
            phase_next = PH_IDLE;
            side_next  = SIDE_NONE;
            pin_next   = 1'b0;
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    start_next = ms_reg;
                    phase_next = PH_DEBOUNCE;
                end
                PH_DEBOUNCE:
                begin
                    if (expired)
                    begin
                        pin_next = 1'b1;
                        if (above)
                        begin
                            left_next = left_reg + 1'b1;
                            side_next = SIDE_LEFT;
                        end
                        else
                        begin
                            right_next = right_reg + 1'b1;
                            side_next  = SIDE_RIGHT;
                        end
                        event_c    = side_next;
                        phase_next = PH_SENT;
                    end
                end
                PH_SENT:
                begin
                    phase_next = PH_SENT;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end

        rep = (cfg.report_period_ms != '0) && (mod_rem == '0) && !busy_reg;
        if (!rep)
        begin
            level_c = LEVEL_IN;
        end
        else if (above)
        begin
            level_c = LEVEL_ABOVE;
        end
        else if (below)
        begin
            level_c = LEVEL_BELOW;
        end
        else
        begin
            level_c = LEVEL_IN;
        end
    end

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    st_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                if (finish && empty)
                begin
                    st_next = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            phase_reg     <= PH_IDLE;
            ms_reg        <= '0;
            start_reg     <= '0;
            left_reg      <= '0;
            right_reg     <= '0;
            side_reg      <= SIDE_NONE;
            pin_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (finish)
            begin
                phase_reg <= phase_next;
                start_reg <= start_next;
                left_reg  <= left_next;
                right_reg <= right_next;
                side_reg  <= side_next;
                pin_reg   <= pin_next;
            end
            if (pop)
            begin
                ms_reg <= ms_tick;
            end
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            zero_reg <= entry[2*SAMPLE_BITS+1];
            busy_reg <= entry[2*SAMPLE_BITS+2];
        end
        if (finish)
        begin
            bal_reg   <= sel;
            event_reg <= event_c;
            rep_reg   <= rep;
            chart_reg <= rep && cfg.chart_enable;
            level_reg <= level_c;
            blink_reg <= ms_reg[BLINK_BIT];
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.balance      = bal_reg;
    assign result.lick_event   = event_reg;
    assign result.report_valid = rep_reg;
    assign result.chart_valid  = chart_reg;
    assign result.level_flag   = level_reg;
    assign result.detect_pin   = pin_reg;
    assign result.blink        = blink_reg;
    assign result.left_total   = left_reg;
    assign result.right_total  = right_reg;
    assign result.stable_side  = side_reg;

endmodule
